>>> src/buzzer_siren_and_beep_pattern_generator_macros.svh
// Assertion helpers; they expect clk and rst_n in scope.
`ifndef BUZZER_SIREN_AND_BEEP_PATTERN_GENERATOR_MACROS_SVH
`define BUZZER_SIREN_AND_BEEP_PATTERN_GENERATOR_MACROS_SVH

// cond must hold at every clock edge out of reset
`define BSPG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define BSPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/bspg_pkg.sv
`timescale 1ns / 1ps

package bspg_pkg;

    localparam int unsigned DEF_TONE_CLOCK_HZ = 2000000;
    localparam int unsigned DEF_TIME_WIDTH    = 16;

    localparam int unsigned BEEP_HZ = 3000;

    localparam int unsigned FREQ_W   = 15;
    localparam int unsigned STEP_W   = 11;
    localparam int unsigned STIME_W  = 10;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned HIGH_W   = 15;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FREQ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIREN_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_OFF    = 3'd6;

    // register reset values
    localparam logic [FREQ_W-1:0]  RST_SWEEP_LOW  = 15'd800;
    localparam logic [FREQ_W-1:0]  RST_SWEEP_HIGH = 15'd2000;
    localparam logic [STEP_W-1:0]  RST_STEP_FREQ  = 11'd100;
    localparam logic [STIME_W-1:0] RST_STEP_TIME  = 10'd50;
    localparam logic [LEN_W-1:0]   RST_SIREN_LEN  = 16'd5000;
    localparam logic [LEN_W-1:0]   RST_BEEP_ON    = 16'd200;
    localparam logic [LEN_W-1:0]   RST_BEEP_OFF   = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_COMMAND = 2'd1,
        OP_BEEP    = 2'd2
    } op_t;

    localparam logic [7:0] CMD_STOP    = 8'd0;
    localparam logic [7:0] CMD_SIREN   = 8'd1;
    localparam logic [7:0] CMD_ENABLE  = 8'd2;
    localparam logic [7:0] CMD_DISABLE = 8'd3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BEEP  = 2'd1,
        MODE_SIREN = 2'd2
    } mode_t;

endpackage

>>> src/bspg_if.sv
`timescale 1ns / 1ps

interface bspg_item_if;
    import bspg_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [7:0]        command;
    logic [LEN_W-1:0]  beep_length;

    modport source (output valid, output operation, output command, output beep_length,
                    input ready);
    modport sink   (input valid, input operation, input command, input beep_length,
                    output ready);
endinterface

interface bspg_result_if;
    import bspg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 tone_on;
    logic [PERIOD_W-1:0]  tone_period;
    logic [HIGH_W-1:0]    tone_high;
    logic [PERIOD_W-1:0]  tone_low;
    logic [1:0]           active_pattern;
    logic                 buzzer_allowed;

    modport source (output valid, output tone_on, output tone_period, output tone_high,
                    output tone_low, output active_pattern, output buzzer_allowed,
                    input ready);
    modport sink   (input valid, input tone_on, input tone_period, input tone_high,
                    input tone_low, input active_pattern, input buzzer_allowed,
                    output ready);
endinterface

>>> src/buzzer_siren_and_beep_pattern_generator.sv
// Buzzer pattern generator: one request in, one result out. A request that needs no division
// (timer tick with no siren step, any command but siren start, start beeping) goes straight to
// ST_SEND, where the result register loads and item.ready returns in the same cycle. A request
// that sets a new siren frequency (siren start, siren step) runs a restoring divider for
// TONE_CLOCK_HZ / frequency. The divider produces one quotient bit per cycle over the bit width
// of TONE_CLOCK_HZ (21 bits at 2 MHz), then stores the tone in ST_DIV and passes to ST_SEND.
// A zero frequency skips the divider. item.ready is high only while no request is in work. The
// result register holds one finished result, so a new request may be accepted while that result
// waits. That request then stalls before its own result for as long as the older result stays
// untaken.
`timescale 1ns / 1ps
`include "buzzer_siren_and_beep_pattern_generator_macros.svh"

module buzzer_siren_and_beep_pattern_generator #(
    parameter int unsigned TONE_CLOCK_HZ = bspg_pkg::DEF_TONE_CLOCK_HZ,
    parameter int unsigned TIME_WIDTH    = bspg_pkg::DEF_TIME_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bspg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bspg_pkg::CFG_DATA_W-1:0]     cfg_data,
    bspg_item_if.sink                           item,
    bspg_result_if.source                       result
);
    import bspg_pkg::*;

    localparam int unsigned DIV_W   = $clog2(TONE_CLOCK_HZ + 1);
    localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
    localparam int unsigned BEEP_PERIOD = (TONE_CLOCK_HZ + BEEP_HZ / 2) / BEEP_HZ;
    localparam int unsigned BEEP_HIGH   = (BEEP_PERIOD + 1) / 2;
    localparam int unsigned BEEP_LOW    = BEEP_PERIOD - BEEP_HIGH;
    localparam logic [DIV_W-1:0] DIVIDEND  = DIV_W'(TONE_CLOCK_HZ);
    localparam logic [DIV_W-1:0] PERIOD_MAX = DIV_W'(65535);
    localparam logic [DIV_W-1:0] PERIOD_MIN = DIV_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEND
    } state_t;

    function automatic logic [TIME_WIDTH-1:0] to_time(input logic [15:0] v);
        logic [TIME_WIDTH+15:0] ext;
        ext = {{TIME_WIDTH{1'b0}}, v};
        return ext[TIME_WIDTH-1:0];
    endfunction

    // configuration
    logic [FREQ_W-1:0]  sweep_low_reg, sweep_high_reg;
    logic [STEP_W-1:0]  step_freq_reg;
    logic [STIME_W-1:0] step_time_reg;
    logic [LEN_W-1:0]   siren_len_reg, beep_on_reg, beep_off_reg;

    // pattern state
    state_t                state_reg, state_next;
    logic                  allowed_reg, allowed_next;
    mode_t                 mode_reg, mode_next;
    logic                  tone_reg, tone_next;
    logic                  phase_on_reg, phase_on_next;
    logic [TIME_WIDTH-1:0] time_left_reg, time_left_next;
    logic [TIME_WIDTH-1:0] ticks_reg, ticks_next;
    logic [FREQ_W-1:0]     sweep_freq_reg, sweep_freq_next;
    logic                  rising_reg, rising_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [HIGH_W-1:0]     high_reg, high_next;
    logic [PERIOD_W-1:0]   low_reg, low_next;

    // divider
    logic [FREQ_W-1:0] div_d_reg, div_d_next;
    logic [FREQ_W-1:0] div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]  div_q_reg, div_q_next;
    logic [CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    // result register
    logic                res_valid_reg, res_valid_next;
    logic                res_tone_reg, res_tone_next;
    logic [PERIOD_W-1:0] res_period_reg, res_period_next;
    logic [HIGH_W-1:0]   res_high_reg, res_high_next;
    logic [PERIOD_W-1:0] res_low_reg, res_low_next;
    mode_t               res_mode_reg, res_mode_next;
    logic                res_allowed_reg, res_allowed_next;

    // scratch
    logic                  sched_do;
    logic [TIME_WIDTH-1:0] sched_in, sched_ivl;
    logic                  div_go;
    logic [FREQ_W-1:0]     div_f;
    logic [16:0]           nf;
    logic [FREQ_W:0]       div_sh;
    logic                  div_ge;
    logic [DIV_W-1:0]      per_clamped;

    assign item.ready = (state_reg == ST_IDLE);

    assign result.valid          = res_valid_reg;
    assign result.tone_on        = res_tone_reg;
    assign result.tone_period    = res_period_reg;
    assign result.tone_high      = res_high_reg;
    assign result.tone_low       = res_low_reg;
    assign result.active_pattern = res_mode_reg;
    assign result.buzzer_allowed = res_allowed_reg;

    always_comb
    begin
        state_next      = state_reg;
        allowed_next    = allowed_reg;
        mode_next       = mode_reg;
        tone_next       = tone_reg;
        phase_on_next   = phase_on_reg;
        time_left_next  = time_left_reg;
        ticks_next      = ticks_reg;
        sweep_freq_next = sweep_freq_reg;
        rising_next     = rising_reg;
        period_next     = period_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        div_d_next      = div_d_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        div_cnt_next    = div_cnt_reg;
        res_valid_next  = res_valid_reg;
        res_tone_next   = res_tone_reg;
        res_period_next = res_period_reg;
        res_high_next   = res_high_reg;
        res_low_next    = res_low_reg;
        res_mode_next   = res_mode_reg;
        res_allowed_next = res_allowed_reg;

        sched_do  = 1'b0;
        sched_in  = '0;
        sched_ivl = '0;
        div_go    = 1'b0;
        div_f     = '0;
        nf        = '0;
        div_sh    = {div_rem_reg, div_q_reg[DIV_W-1]};
        div_ge    = (div_sh >= {1'b0, div_d_reg});
        per_clamped = div_q_reg;
        if (div_q_reg > PERIOD_MAX)
        begin
            per_clamped = PERIOD_MAX;
        end
        else if (div_q_reg < PERIOD_MIN)
        begin
            per_clamped = PERIOD_MIN;
        end

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_SEND;
                    unique case (item.operation)
                        OP_TICK:
                        begin
                            if (mode_reg != MODE_IDLE)
                            begin
                                if (ticks_reg <= TIME_WIDTH'(1))
                                begin
                                    ticks_next = '0;
                                    if (time_left_reg == '0)
                                    begin
                                        // pattern ran out
                                        tone_next = 1'b0;
                                        mode_next = MODE_IDLE;
                                        if (mode_reg == MODE_BEEP)
                                        begin
                                            phase_on_next = 1'b0;
                                        end
                                    end
                                    else if (mode_reg == MODE_BEEP)
                                    begin
                                        sched_do      = 1'b1;
                                        tone_next     = !phase_on_reg;
                                        phase_on_next = !phase_on_reg;
                                        sched_in      = phase_on_reg ? to_time(beep_off_reg)
                                                                     : to_time(beep_on_reg);
                                    end
                                    else
                                    begin
                                        if (rising_reg)
                                        begin
                                            nf = {2'b0, sweep_freq_reg} + {6'b0, step_freq_reg};
                                        end
                                        else
                                        begin
                                            nf = {2'b0, sweep_freq_reg} - {6'b0, step_freq_reg};
                                        end
                                        if ($signed(nf) >= $signed({2'b0, sweep_high_reg}))
                                        begin
                                            nf          = {2'b0, sweep_high_reg};
                                            rising_next = 1'b0;
                                        end
                                        else if ($signed(nf) <= $signed({2'b0, sweep_low_reg}))
                                        begin
                                            nf          = {2'b0, sweep_low_reg};
                                            rising_next = 1'b1;
                                        end
                                        sweep_freq_next = nf[FREQ_W-1:0];
                                        div_go   = 1'b1;
                                        div_f    = nf[FREQ_W-1:0];
                                        sched_do = 1'b1;
                                        sched_in = to_time({6'b0, step_time_reg});
                                    end
                                end
                                else
                                begin
                                    ticks_next = ticks_reg - TIME_WIDTH'(1);
                                end
                            end
                        end
                        OP_COMMAND:
                        begin
                            unique case (item.command) inside
                                CMD_STOP, CMD_DISABLE:
                                begin
                                    if (item.command == CMD_DISABLE)
                                    begin
                                        allowed_next = 1'b0;
                                    end
                                    if (mode_reg == MODE_SIREN)
                                    begin
                                        sweep_freq_next = sweep_low_reg;
                                        rising_next     = 1'b1;
                                    end
                                    mode_next      = MODE_IDLE;
                                    time_left_next = '0;
                                    ticks_next     = '0;
                                    phase_on_next  = 1'b0;
                                    tone_next      = 1'b0;
                                end
                                CMD_SIREN:
                                begin
                                    if (allowed_reg)
                                    begin
                                        phase_on_next   = 1'b0;
                                        mode_next       = MODE_SIREN;
                                        sweep_freq_next = sweep_low_reg;
                                        div_go          = 1'b1;
                                        div_f           = sweep_low_reg;
                                        tone_next       = 1'b1;
                                        time_left_next  = to_time(siren_len_reg);
                                        rising_next     = 1'b1;
                                        ticks_next      = '0;
                                    end
                                end
                                CMD_ENABLE:
                                begin
                                    allowed_next = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        OP_BEEP:
                        begin
                            if (allowed_reg)
                            begin
                                mode_next     = MODE_BEEP;
                                period_next   = PERIOD_W'(BEEP_PERIOD);
                                high_next     = HIGH_W'(BEEP_HIGH);
                                low_next      = PERIOD_W'(BEEP_LOW);
                                phase_on_next = 1'b1;
                                tone_next     = 1'b1;
                                sched_do      = 1'b1;
                                sched_in      = to_time(beep_on_reg);
                                // schedule runs against the new length
                                time_left_next = to_time(item.beep_length);
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (sched_do)
                    begin
                        sched_ivl      = (time_left_next < sched_in) ? time_left_next : sched_in;
                        time_left_next = time_left_next - sched_ivl;
                        ticks_next     = sched_ivl;
                    end

                    // zero frequency keeps the old tone
                    if (div_go && (div_f != '0))
                    begin
                        state_next   = ST_DIV;
                        div_d_next   = div_f;
                        div_rem_next = '0;
                        div_q_next   = DIVIDEND;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == CNT_W'(DIV_W))
                begin
                    period_next = per_clamped[PERIOD_W-1:0];
                    high_next   = per_clamped[PERIOD_W-1:1];
                    low_next    = per_clamped[PERIOD_W-1:0] - {1'b0, per_clamped[PERIOD_W-1:1]};
                    state_next  = ST_SEND;
                end
                else
                begin
                    div_rem_next = div_ge ? FREQ_W'(div_sh - {1'b0, div_d_reg})
                                          : div_sh[FREQ_W-1:0];
                    div_q_next   = {div_q_reg[DIV_W-2:0], div_ge};
                    div_cnt_next = div_cnt_reg + CNT_W'(1);
                end
            end
            ST_SEND:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next   = 1'b1;
                    res_tone_next    = tone_reg;
                    res_period_next  = period_reg;
                    res_high_next    = high_reg;
                    res_low_next     = low_reg;
                    res_mode_next    = mode_reg;
                    res_allowed_next = allowed_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_low_reg   <= RST_SWEEP_LOW;
            sweep_high_reg  <= RST_SWEEP_HIGH;
            step_freq_reg   <= RST_STEP_FREQ;
            step_time_reg   <= RST_STEP_TIME;
            siren_len_reg   <= RST_SIREN_LEN;
            beep_on_reg     <= RST_BEEP_ON;
            beep_off_reg    <= RST_BEEP_OFF;
            state_reg       <= ST_IDLE;
            allowed_reg     <= 1'b1;
            mode_reg        <= MODE_IDLE;
            tone_reg        <= 1'b0;
            phase_on_reg    <= 1'b0;
            time_left_reg   <= '0;
            ticks_reg       <= '0;
            sweep_freq_reg  <= RST_SWEEP_LOW;
            rising_reg      <= 1'b1;
            period_reg      <= PERIOD_W'(BEEP_PERIOD);
            high_reg        <= HIGH_W'(BEEP_HIGH);
            low_reg         <= PERIOD_W'(BEEP_LOW);
            div_d_reg       <= '0;
            div_rem_reg     <= '0;
            div_q_reg       <= '0;
            div_cnt_reg     <= '0;
            res_valid_reg   <= 1'b0;
            res_tone_reg    <= 1'b0;
            res_period_reg  <= '0;
            res_high_reg    <= '0;
            res_low_reg     <= '0;
            res_mode_reg    <= MODE_IDLE;
            res_allowed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SWEEP_LOW:  sweep_low_reg  <= cfg_data[FREQ_W-1:0];
                    REG_SWEEP_HIGH: sweep_high_reg <= cfg_data[FREQ_W-1:0];
                    REG_STEP_FREQ:  step_freq_reg  <= cfg_data[STEP_W-1:0];
                    REG_STEP_TIME:  step_time_reg  <= cfg_data[STIME_W-1:0];
                    REG_SIREN_LEN:  siren_len_reg  <= cfg_data[LEN_W-1:0];
                    REG_BEEP_ON:    beep_on_reg    <= cfg_data[LEN_W-1:0];
                    REG_BEEP_OFF:   beep_off_reg   <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg       <= state_next;
            allowed_reg     <= allowed_next;
            mode_reg        <= mode_next;
            tone_reg        <= tone_next;
            phase_on_reg    <= phase_on_next;
            time_left_reg   <= time_left_next;
            ticks_reg       <= ticks_next;
            sweep_freq_reg  <= sweep_freq_next;
            rising_reg      <= rising_next;
            period_reg      <= period_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            div_d_reg       <= div_d_next;
            div_rem_reg     <= div_rem_next;
            div_q_reg       <= div_q_next;
            div_cnt_reg     <= div_cnt_next;
            res_valid_reg   <= res_valid_next;
            res_tone_reg    <= res_tone_next;
            res_period_reg  <= res_period_next;
            res_high_reg    <= res_high_next;
            res_low_reg     <= res_low_next;
            res_mode_reg    <= res_mode_next;
            res_allowed_reg <= res_allowed_next;
        end
    end

    `BSPG_ASSERT_ALWAYS(a_tone_split, ({1'b0, high_reg} + low_reg) == period_reg, "high plus low differs from period")
    `BSPG_ASSERT_ALWAYS(a_period_min, period_reg >= PERIOD_W'(3), "tone period below three")
    `BSPG_ASSERT_IMPLY(a_idle_silent, mode_reg == MODE_IDLE, !tone_reg, "tone running with no pattern")
    `BSPG_ASSERT_IMPLY(a_div_live, state_reg == ST_DIV, (div_d_reg != '0) && (div_cnt_reg <= CNT_W'(DIV_W)), "divider running with zero divisor or overrun")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bspg_pkg::*;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] period;
        logic [14:0] high_cnt;
        logic [15:0] low_cnt;
        logic [1:0]  pattern;
        logic        allowed;
    } tone_status_t;

    typedef struct {
        logic [14:0] low_f;
        logic [14:0] high_f;
        logic [10:0] step_f;
        logic [9:0]  step_t;
        logic [15:0] siren_t;
        logic [15:0] on_t;
        logic [15:0] off_t;
    } sweep_setup_t;

    class tone_scoreboard;
        // register copies
        logic [14:0] low_f, high_f;
        logic [10:0] step_f;
        logic [9:0]  step_t;
        logic [15:0] siren_t, on_t, off_t;
        // pattern state
        bit          allowed, running, phase_on, rising;
        mode_t       mode;
        logic [15:0] time_left, countdown;
        logic [14:0] freq;
        logic [15:0] period, high_cnt, low_cnt;

        tone_status_t pending[$];
        int          mismatches;
        int          failures;

        function new();
            low_f = RST_SWEEP_LOW;
            high_f = RST_SWEEP_HIGH;
            step_f = RST_STEP_FREQ;
            step_t = RST_STEP_TIME;
            siren_t = RST_SIREN_LEN;
            on_t = RST_BEEP_ON;
            off_t = RST_BEEP_OFF;
            allowed = 1'b1;
            running = 1'b0;
            phase_on = 1'b0;
            rising = 1'b1;
            mode = MODE_IDLE;
            time_left = '0;
            countdown = '0;
            freq = RST_SWEEP_LOW;
            beep_tone();
            mismatches = 0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SWEEP_LOW:  low_f = val[14:0];
                REG_SWEEP_HIGH: high_f = val[14:0];
                REG_STEP_FREQ:  step_f = val[10:0];
                REG_STEP_TIME:  step_t = val[9:0];
                REG_SIREN_LEN:  siren_t = val;
                REG_BEEP_ON:    on_t = val;
                REG_BEEP_OFF:   off_t = val;
                default: ;
            endcase
        endfunction

        function void beep_tone();
            int unsigned p;
            p = (DEF_TONE_CLOCK_HZ + BEEP_HZ / 2) / BEEP_HZ;
            period = p[15:0];
            high_cnt = (period + 16'd1) / 2;
            low_cnt = period - high_cnt;
        endfunction

        // zero frequency leaves the tone registers alone
        function void retune(logic [14:0] f);
            int unsigned p;
            if (f == 0)
                return;
            p = DEF_TONE_CLOCK_HZ / f;
            if (p < 3)
                p = 3;
            if (p > 65535)
                p = 65535;
            period = p[15:0];
            high_cnt = period / 2;
            low_cnt = period - high_cnt;
        endfunction

        function void reschedule(logic [15:0] interval);
            if (time_left < interval)
                interval = time_left;
            time_left = time_left - interval;
            countdown = interval;
        endfunction

        function void halt();
            if (mode == MODE_SIREN)
            begin
                freq = low_f;
                rising = 1'b1;
            end
            mode = MODE_IDLE;
            time_left = '0;
            countdown = '0;
            phase_on = 1'b0;
            running = 1'b0;
        endfunction

        function void beep_event();
            if (time_left == 0)
            begin
                running = 1'b0;
                phase_on = 1'b0;
                mode = MODE_IDLE;
            end
            else if (phase_on)
            begin
                running = 1'b0;
                phase_on = 1'b0;
                reschedule(off_t);
            end
            else
            begin
                running = 1'b1;
                phase_on = 1'b1;
                reschedule(on_t);
            end
        endfunction

        function void siren_event();
            int nf;
            if (time_left == 0)
            begin
                running = 1'b0;
                mode = MODE_IDLE;
                return;
            end
            nf = rising ? int'(freq) + int'(step_f) : int'(freq) - int'(step_f);
            // clamp at the top first, then saturate at the bottom
            if (nf >= int'(high_f))
            begin
                nf = int'(high_f);
                rising = 1'b0;
            end
            else if (nf <= int'(low_f))
            begin
                nf = int'(low_f);
                rising = 1'b1;
            end
            freq = nf[14:0];
            retune(freq);
            reschedule({6'd0, step_t});
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] cmd, logic [15:0] len);
            tone_status_t st;
            if (op == OP_TICK)
            begin
                if (mode == MODE_BEEP || mode == MODE_SIREN)
                begin
                    if (countdown <= 1)
                    begin
                        countdown = '0;
                        if (mode == MODE_BEEP)
                            beep_event();
                        else
                            siren_event();
                    end
                    else
                        countdown = countdown - 16'd1;
                end
            end
            else if (op == OP_COMMAND)
            begin
                if (cmd == CMD_STOP)
                    halt();
                else if (cmd == CMD_SIREN && allowed)
                begin
                    phase_on = 1'b0;
                    mode = MODE_SIREN;
                    freq = low_f;
                    retune(freq);
                    running = 1'b1;
                    time_left = siren_t;
                    rising = 1'b1;
                    countdown = '0;
                end
                else if (cmd == CMD_ENABLE)
                    allowed = 1'b1;
                else if (cmd == CMD_DISABLE)
                begin
                    allowed = 1'b0;
                    halt();
                end
            end
            else if (op == OP_BEEP && allowed)
            begin
                mode = MODE_BEEP;
                beep_tone();
                time_left = len;
                phase_on = 1'b1;
                running = 1'b1;
                reschedule(on_t);
            end
            st.tone_on = running;
            st.period = period;
            st.high_cnt = high_cnt[14:0];
            st.low_cnt = low_cnt;
            st.pattern = mode;
            st.allowed = allowed;
            pending.push_back(st);
        endfunction

        function void check_result(tone_status_t got);
            tone_status_t want;
            if (pending.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: on=%0d period=%0d high=%0d low=%0d pattern=%0d allowed=%0d",
                             got.tone_on, got.period, got.high_cnt, got.low_cnt, got.pattern,
                             got.allowed);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected on=%0d period=%0d high=%0d low=%0d pattern=%0d allowed=%0d, got on=%0d period=%0d high=%0d low=%0d pattern=%0d allowed=%0d",
                             want.tone_on, want.period, want.high_cnt, want.low_cnt, want.pattern,
                             want.allowed, got.tone_on, got.period, got.high_cnt, got.low_cnt,
                             got.pattern, got.allowed);
            end
        endfunction
    endclass

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int idle_pct;
    int stall_pct;

    tone_scoreboard sb = new();

    bspg_item_if   item_ch ();
    bspg_result_if result_ch ();

    buzzer_siren_and_beep_pattern_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("buzzer_siren_and_beep_pattern_generator test failed");
        $finish;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        tone_status_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.tone_on = result_ch.tone_on;
            got.period = result_ch.tone_period;
            got.high_cnt = result_ch.tone_high;
            got.low_cnt = result_ch.tone_low;
            got.pattern = result_ch.active_pattern;
            got.allowed = result_ch.buzzer_allowed;
            sb.check_result(got);
        end
    end

    task automatic send_request(logic [1:0] op, logic [7:0] cmd, logic [15:0] len);
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.command <= cmd;
        item_ch.beep_length <= len;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_request(op, cmd, len);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lower valid and drain every outstanding request
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_setup(sweep_setup_t s);
        write_reg(REG_SWEEP_LOW, {1'b0, s.low_f});
        write_reg(REG_SWEEP_HIGH, {1'b0, s.high_f});
        write_reg(REG_STEP_FREQ, {5'd0, s.step_f});
        write_reg(REG_STEP_TIME, {6'd0, s.step_t});
        write_reg(REG_SIREN_LEN, s.siren_t);
        write_reg(REG_BEEP_ON, s.on_t);
        write_reg(REG_BEEP_OFF, s.off_t);
        cfg_we <= 1'b0;
    endtask

    function automatic sweep_setup_t pick_setup(int phase);
        sweep_setup_t s;
        case (phase)
            0: s = '{15'd31, 15'd20000, 11'd2000, 10'd1, 16'd40, 16'd1, 16'd1};
            // zero start frequency, then 1 Hz saturates the period
            1: s = '{15'd0, 15'd500, 11'd1, 10'd2, 16'd30, 16'd2, 16'd3};
            // bounds swapped
            2: s = '{15'd20000, 15'd31, 11'd1000, 10'd3, 16'd40, 16'd65535, 16'd65535};
            3: s = '{15'd500, 15'd3000, 11'd700, 10'd1000, 16'd0, 16'd3, 16'd2};
            default:
            begin
                s.low_f = 15'($urandom_range(31, 20000));
                s.high_f = 15'($urandom_range(31, 20000));
                s.step_f = 11'($urandom_range(1, 2000));
                s.step_t = 10'($urandom_range(1, 4));
                s.siren_t = (phase == 5) ? 16'd65535 : 16'($urandom_range(0, 60));
                s.on_t = 16'($urandom_range(1, 6));
                s.off_t = 16'($urandom_range(1, 6));
            end
        endcase
        return s;
    endfunction

    task automatic random_request();
        int r;
        logic [7:0]  cmd;
        logic [15:0] len;
        r = $urandom_range(99);
        cmd = 8'($urandom());
        len = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 24));
        if (r < 52)
            send_request(OP_TICK, cmd, len);
        else if (r < 62)
            send_request(OP_COMMAND, CMD_SIREN, len);
        else if (r < 72)
            send_request(OP_BEEP, cmd, len);
        else if (r < 77)
            send_request(OP_COMMAND, CMD_STOP, len);
        else if (r < 83)
            send_request(OP_COMMAND, CMD_ENABLE, len);
        else if (r < 86)
            send_request(OP_COMMAND, CMD_DISABLE, len);
        else if (r < 93)
            send_request(OP_COMMAND, 8'($urandom_range(4, 255)), len);
        else
            send_request(OP_UNUSED, cmd, len);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = OP_TICK;
        item_ch.command = CMD_STOP;
        item_ch.beep_length = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle tick, noise, siren start and step, then stop
        send_request(OP_TICK, 8'hFF, 16'hFFFF);
        send_request(OP_UNUSED, 8'h00, 16'h0000);
        send_request(OP_COMMAND, CMD_SIREN, 16'h0000);
        send_request(OP_TICK, 8'h00, 16'h0000);
        send_request(OP_COMMAND, CMD_STOP, 16'h0000);
        settle();
        load_setup('{15'd1000, 15'd1300, 11'd200, 10'd1, 16'd6, 16'd1, 16'd2});

        // zero-length beep ends on the next tick
        send_request(OP_BEEP, 8'h00, 16'd0);
        send_request(OP_TICK, 8'h00, 16'd0);
        // siren up, clamp at top, down, saturate at bottom, then run out
        send_request(OP_COMMAND, CMD_SIREN, 16'd0);
        repeat (7) send_request(OP_TICK, 8'h00, 16'd0);
        send_request(OP_COMMAND, 8'h80, 16'd0);
        // patterns cancel each other
        send_request(OP_BEEP, 8'h00, 16'd5);
        send_request(OP_TICK, 8'h00, 16'd0);
        send_request(OP_COMMAND, CMD_SIREN, 16'd0);
        send_request(OP_BEEP, 8'h00, 16'hFFFF);
        // disabled buzzer ignores both starts
        send_request(OP_COMMAND, CMD_DISABLE, 16'd0);
        send_request(OP_COMMAND, CMD_SIREN, 16'd0);
        send_request(OP_BEEP, 8'h00, 16'd9);
        send_request(OP_COMMAND, CMD_ENABLE, 16'd0);
        send_request(OP_COMMAND, CMD_SIREN, 16'd0);
        send_request(OP_TICK, 8'h00, 16'd0);
        send_request(OP_COMMAND, CMD_STOP, 16'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            load_setup(pick_setup(phase));
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            repeat (ITEMS_PER_PHASE) random_request();
        end

        settle();
        repeat (30) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("buzzer_siren_and_beep_pattern_generator test passed");
        else
            $display("buzzer_siren_and_beep_pattern_generator test failed");
        $finish;
    end
endmodule
